// ===== rtl/aaru_pkg.sv =====
// shared types and constants for the axis-angle rotation update block
// no dependencies; imported by every module of the block

package aaru_pkg;

	// signed Q2.30 / Q16.16 field word
	typedef logic signed [31:0] q30_t;
	// cordic datapath word
	typedef logic signed [33:0] cw_t;

	localparam logic [31:0] TIME_STEP_RST = 32'd1092;

	// angle constants, Q32.32
	localparam logic [34:0]        TWO_PI_Q32  = 35'd26986075409;
	localparam logic signed [36:0] TWO_PI_S    = 37'sd26986075409;
	localparam logic signed [36:0] PI_Q32      = 37'sd13493037705;
	localparam logic signed [36:0] HALF_PI_Q32 = 37'sd6746518852;

	// cordic start value (inverse gain) and unity, Q2.30
	localparam cw_t                CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

	// arctan(2^-i) in Q2.30
	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
		32'd67021686, 32'd33543515, 32'd16775850, 32'd8388437,
		32'd4194282, 32'd2097149, 32'd1048576, 32'd524288,
		32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128,
		32'd64, 32'd32, 32'd16, 32'd8,
		32'd4, 32'd2, 32'd1, 32'd0
	};

endpackage

// ===== rtl/axis_angle_rotation_update.sv =====
// axis-angle (rodrigues) orientation update, top level
// depends on aaru_pkg, aaru_isqrt, aaru_cordic
//
// Usage: one item per body carries its angular velocity (Q16.16) and its
// present 3x3 basis (Q2.30); one result item carries the rotated basis,
// saturated to 32 bits. Both channels use valid/stall; an item moves at a
// clock edge with valid high and stall low.
// Throughput is one item per cycle while the receiver does not stall: the
// whole pipeline (squares, 32 square-root stages, angle multiply, 31 divide
// and angle-reduction stages, cordic stages, rodrigues and matrix product
// stages) advances together in each cycle that it is not held.
// The pipeline moves on every cycle unless a finished item sits at the
// output and the receiver stalls; then all stages hold and in_stall is high,
// so nothing is lost or repeated.
// time_step is written through cfg_we/cfg_wdata; the user must write it only
// while the pipeline is empty, which the block does not enforce. Reset clears
// all valid bits and loads time_step with 1092 (about 1/60 s).

module axis_angle_rotation_update #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  aaru_pkg::q30_t     ang_vel_x,
	input  aaru_pkg::q30_t     ang_vel_y,
	input  aaru_pkg::q30_t     ang_vel_z,
	input  aaru_pkg::q30_t     basis_r0c0,
	input  aaru_pkg::q30_t     basis_r0c1,
	input  aaru_pkg::q30_t     basis_r0c2,
	input  aaru_pkg::q30_t     basis_r1c0,
	input  aaru_pkg::q30_t     basis_r1c1,
	input  aaru_pkg::q30_t     basis_r1c2,
	input  aaru_pkg::q30_t     basis_r2c0,
	input  aaru_pkg::q30_t     basis_r2c1,
	input  aaru_pkg::q30_t     basis_r2c2,
	output logic               out_valid,
	input  logic               out_stall,
	output aaru_pkg::q30_t     new_r0c0,
	output aaru_pkg::q30_t     new_r0c1,
	output aaru_pkg::q30_t     new_r0c2,
	output aaru_pkg::q30_t     new_r1c0,
	output aaru_pkg::q30_t     new_r1c1,
	output aaru_pkg::q30_t     new_r1c2,
	output aaru_pkg::q30_t     new_r2c0,
	output aaru_pkg::q30_t     new_r2c1,
	output aaru_pkg::q30_t     new_r2c2
);
	import aaru_pkg::*;

	localparam int NC        = CORDIC_STEPS;
	localparam int DIV_STEPS = 31;
	localparam int LAT       = 72 + NC;
	// stage numbers: 1 squares, 2 sum, 3..34 sqrt, 35 angle multiply,
	// 36..66 divide/reduce, 67 fold, 68..67+NC cordic, then R1 R2 R3 M1 M2

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// valid bits travel with the items
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	// time step register
	logic [31:0] time_step_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
		end else if (cfg_we) begin
			time_step_q <= cfg_wdata;
		end
	end

	// basis delay line, stage 1 .. LAT-2
	q30_t bas_in [9];
	q30_t bas_q  [LAT-2][9];
	assign bas_in[0] = basis_r0c0;
	assign bas_in[1] = basis_r0c1;
	assign bas_in[2] = basis_r0c2;
	assign bas_in[3] = basis_r1c0;
	assign bas_in[4] = basis_r1c1;
	assign bas_in[5] = basis_r1c2;
	assign bas_in[6] = basis_r2c0;
	assign bas_in[7] = basis_r2c1;
	assign bas_in[8] = basis_r2c2;

	always_ff @(posedge clk) begin
		if (en) begin
			bas_q[0] <= bas_in;
			for (int k = 1; k < LAT - 2; k++) begin
				bas_q[k] <= bas_q[k-1];
			end
		end
	end

	// stage 1: magnitudes, signs, squares
	q30_t        vel_in [3];
	logic [31:0] mag_in [3];
	logic [2:0]  sgn_in;
	logic [63:0] sq_in  [3];
	logic [63:0] sq_s1  [3];
	assign vel_in[0] = ang_vel_x;
	assign vel_in[1] = ang_vel_y;
	assign vel_in[2] = ang_vel_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sgn_in[i] = vel_in[i][31];
			mag_in[i] = vel_in[i][31] ? 32'(-vel_in[i]) : 32'(vel_in[i]);
			sq_in[i]  = 64'(mag_in[i]) * 64'(mag_in[i]);
		end
	end

	// magnitude line, stage 1 .. 34; sign line, stage 1 .. 66
	logic [31:0] mag_q [34][3];
	logic [2:0]  sgn_q [66];
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1    <= sq_in;
			mag_q[0] <= mag_in;
			sgn_q[0] <= sgn_in;
			for (int k = 1; k < 34; k++) begin
				mag_q[k] <= mag_q[k-1];
			end
			for (int k = 1; k < 66; k++) begin
				sgn_q[k] <= sgn_q[k-1];
			end
		end
	end

	// stage 2: sum of squares
	logic [63:0] sum_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	// stages 3..34: square root
	logic [31:0] speed_c;
	aaru_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.op   (sum_s2),
		.root (speed_c)
	);

	// stage 35: angle = speed * time_step
	logic [63:0] angle_s35;
	logic [31:0] speed_s35;
	logic [31:0] mag_s35 [3];
	logic        zero_in;
	assign zero_in = (speed_c == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s35 <= 64'(speed_c) * 64'(time_step_q);
			speed_s35 <= speed_c;
			mag_s35   <= mag_q[33];
		end
	end

	// zero-speed flag line, stage 35 .. 69+NC
	logic zero_q [35+NC];
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= zero_in;
			for (int k = 1; k < 35 + NC; k++) begin
				zero_q[k] <= zero_q[k-1];
			end
		end
	end

	// stages 36..66: axis division and angle reduction modulo 2*pi
	logic [32:0] rem_q [3][DIV_STEPS];
	logic [30:0] quo_q [3][DIV_STEPS];
	logic [31:0] spd_q [DIV_STEPS];
	logic [63:0] th_q  [DIV_STEPS];
	logic [32:0] rem_c [3][DIV_STEPS];
	logic [30:0] quo_c [3][DIV_STEPS];
	logic [31:0] spd_c [DIV_STEPS];
	logic [63:0] th_c  [DIV_STEPS];
	logic [32:0] rem_nx[3][DIV_STEPS];
	logic [30:0] quo_nx[3][DIV_STEPS];
	logic [63:0] th_nx [DIV_STEPS];

	always_comb begin
		spd_c[0] = speed_s35;
		th_c[0]  = angle_s35;
		for (int i = 0; i < 3; i++) begin
			rem_c[i][0] = {1'b0, mag_s35[i]};
			quo_c[i][0] = '0;
		end
		for (int t = 1; t < DIV_STEPS; t++) begin
			spd_c[t] = spd_q[t-1];
			th_c[t]  = th_q[t-1];
			for (int i = 0; i < 3; i++) begin
				rem_c[i][t] = {rem_q[i][t-1][31:0], 1'b0};
				quo_c[i][t] = quo_q[i][t-1];
			end
		end
	end

	// one quotient bit per lane and one conditional subtract of 2*pi << k
	always_comb begin
		logic        ge;
		logic [65:0] cst;
		for (int t = 0; t < DIV_STEPS; t++) begin
			for (int i = 0; i < 3; i++) begin
				ge = rem_c[i][t] >= {1'b0, spd_c[t]};
				rem_nx[i][t] = ge ? rem_c[i][t] - {1'b0, spd_c[t]} : rem_c[i][t];
				quo_nx[i][t] = {quo_c[i][t][29:0], ge};
			end
			cst = 66'(TWO_PI_Q32) << (DIV_STEPS - 1 - t);
			if ({2'b00, th_c[t]} >= cst) begin
				th_nx[t] = th_c[t] - cst[63:0];
			end else begin
				th_nx[t] = th_c[t];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < DIV_STEPS; t++) begin
				spd_q[t] <= spd_c[t];
				th_q[t]  <= th_nx[t];
				for (int i = 0; i < 3; i++) begin
					rem_q[i][t] <= rem_nx[i][t];
					quo_q[i][t] <= quo_nx[i][t];
				end
			end
		end
	end

	// stage 67: fold angle into +-pi/2, signed axis
	logic signed [36:0] th0;
	logic signed [36:0] th1;
	logic signed [36:0] th2;
	logic               flip_in;
	q30_t               axis_in [3];
	cw_t                z0_s67;
	logic               flip_q [NC+1];
	q30_t               axis_q [NC+1][3];

	always_comb begin
		th0 = $signed({2'b00, th_q[DIV_STEPS-1][34:0]});
		th1 = (th0 > PI_Q32) ? th0 - TWO_PI_S : th0;
		if (th1 > HALF_PI_Q32) begin
			th2     = th1 - PI_Q32;
			flip_in = 1'b1;
		end else if (th1 < -HALF_PI_Q32) begin
			th2     = th1 + PI_Q32;
			flip_in = 1'b1;
		end else begin
			th2     = th1;
			flip_in = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			axis_in[i] = sgn_q[65][i] ? -q30_t'({1'b0, quo_q[i][DIV_STEPS-1]})
			                          :  q30_t'({1'b0, quo_q[i][DIV_STEPS-1]});
		end
	end

	// axis and flip lines, stage 67 .. 67+NC
	always_ff @(posedge clk) begin
		if (en) begin
			z0_s67    <= cw_t'(th2 >>> 2);
			flip_q[0] <= flip_in;
			axis_q[0] <= axis_in;
			for (int k = 1; k <= NC; k++) begin
				flip_q[k] <= flip_q[k-1];
				axis_q[k] <= axis_q[k-1];
			end
		end
	end

	// stages 68..67+NC: sine and cosine
	cw_t cx_c;
	cw_t sy_c;
	aaru_cordic #(
		.STEPS (NC)
	) u_cordic (
		.clk   (clk),
		.en    (en),
		.z0    (z0_s67),
		.cos_o (cx_c),
		.sin_o (sy_c)
	);

	// R1: axis outer product and axis * sin
	logic signed [34:0] c_r1;
	logic signed [34:0] s_r1;
	logic signed [63:0] aa_p [3][3];
	logic signed [66:0] as_p [3];
	logic signed [33:0] p_s1 [3][3];
	logic signed [34:0] as_s1[3];
	logic signed [34:0] c_s1;

	always_comb begin
		c_r1 = flip_q[NC] ? -35'(cx_c) : 35'(cx_c);
		s_r1 = flip_q[NC] ? -35'(sy_c) : 35'(sy_c);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				aa_p[i][j] = axis_q[NC][i] * axis_q[NC][j];
			end
			as_p[i] = axis_q[NC][i] * s_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c_r1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[i][j] <= 34'(aa_p[i][j] >>> 30);
				end
				as_s1[i] <= 35'(as_p[i] >>> 30);
			end
		end
	end

	// R2: scale by (1 - cos)
	logic signed [35:0] omc;
	logic signed [69:0] po_p [3][3];
	logic signed [35:0] r_s2 [3][3];
	logic signed [34:0] as_s2[3];
	logic signed [34:0] c_s2;
	assign omc = ONE_Q30 - 36'(c_s1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				po_p[i][j] = p_s1[i][j] * omc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2  <= c_s1;
			as_s2 <= as_s1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_s2[i][j] <= 36'(po_p[i][j] >>> 30);
				end
			end
		end
	end

	// R3: add cos on the diagonal and the cross-product terms
	logic signed [36:0] r_nx [3][3];
	logic signed [36:0] r_s3 [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r_nx[i][j] = 37'(r_s2[i][j]);
			end
			r_nx[i][i] = r_nx[i][i] + 37'(c_s2);
		end
		r_nx[0][1] = r_nx[0][1] - 37'(as_s2[2]);
		r_nx[1][0] = r_nx[1][0] + 37'(as_s2[2]);
		r_nx[0][2] = r_nx[0][2] + 37'(as_s2[1]);
		r_nx[2][0] = r_nx[2][0] - 37'(as_s2[1]);
		r_nx[1][2] = r_nx[1][2] - 37'(as_s2[0]);
		r_nx[2][1] = r_nx[2][1] + 37'(as_s2[0]);
		// zero speed: identity rotation
		if (zero_q[34+NC]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_nx[i][j] = (i == j) ? 37'(ONE_Q30) : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= r_nx;
		end
	end

	// M1: products of rotation and basis, each floor-shifted by 2
	logic signed [68:0] rb_p [3][3][3];
	logic signed [66:0] rb_s4[3][3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					rb_p[i][j][k] = r_s3[i][k] * bas_q[LAT-3][k*3+j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						rb_s4[i][j][k] <= 67'(rb_p[i][j][k] >>> 2);
					end
				end
			end
		end
	end

	// M2: sum, shift and saturate into the output register
	logic signed [68:0] acc   [9];
	logic signed [68:0] accs  [9];
	q30_t               sat_c [9];
	q30_t               out_s5[9];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc[i*3+j] = 69'(rb_s4[i][j][0]) + 69'(rb_s4[i][j][1])
				           + 69'(rb_s4[i][j][2]);
				accs[i*3+j] = acc[i*3+j] >>> 28;
				if (accs[i*3+j] > 69'sh7FFFFFFF) begin
					sat_c[i*3+j] = 32'sh7FFFFFFF;
				end else if (accs[i*3+j] < -69'sh80000000) begin
					sat_c[i*3+j] = 32'sh80000000;
				end else begin
					sat_c[i*3+j] = accs[i*3+j][31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5 <= sat_c;
		end
	end

	assign new_r0c0 = out_s5[0];
	assign new_r0c1 = out_s5[1];
	assign new_r0c2 = out_s5[2];
	assign new_r1c0 = out_s5[3];
	assign new_r1c1 = out_s5[4];
	assign new_r1c2 = out_s5[5];
	assign new_r2c0 = out_s5[6];
	assign new_r2c1 = out_s5[7];
	assign new_r2c2 = out_s5[8];

endmodule

// ===== rtl/aaru_isqrt.sv =====
// pipelined floor square root of a 64 bit value, one result bit per stage
// depends on aaru_pkg

module aaru_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] op,
	output logic [31:0] root
);
	import aaru_pkg::*;

	localparam int STEPS = 32;

	logic [63:0] op_q  [STEPS];
	logic [63:0] res_q [STEPS];
	logic [63:0] op_c  [STEPS];
	logic [63:0] res_c [STEPS];
	logic [63:0] op_nx [STEPS];
	logic [63:0] res_nx[STEPS];

	// stage inputs: first stage from the port, the rest from the previous stage
	always_comb begin
		op_c[0]  = op;
		res_c[0] = '0;
		for (int n = 1; n < STEPS; n++) begin
			op_c[n]  = op_q[n-1];
			res_c[n] = res_q[n-1];
		end
	end

	// one restoring step per stage
	always_comb begin
		logic [63:0] bitv;
		for (int n = 0; n < STEPS; n++) begin
			bitv = 64'd1 << (62 - 2 * n);
			if (op_c[n] >= res_c[n] + bitv) begin
				op_nx[n]  = op_c[n] - (res_c[n] + bitv);
				res_nx[n] = (res_c[n] >> 1) + bitv;
			end else begin
				op_nx[n]  = op_c[n];
				res_nx[n] = res_c[n] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < STEPS; n++) begin
				op_q[n]  <= op_nx[n];
				res_q[n] <= res_nx[n];
			end
		end
	end

	assign root = res_q[STEPS-1][31:0];

endmodule

// ===== rtl/aaru_cordic.sv =====
// pipelined rotation-mode cordic, one iteration per stage, gives cos and sin
// depends on aaru_pkg

module aaru_cordic #(
	parameter int STEPS = 24
) (
	input  logic           clk,
	input  logic           en,
	input  aaru_pkg::cw_t  z0,
	output aaru_pkg::cw_t  cos_o,
	output aaru_pkg::cw_t  sin_o
);
	import aaru_pkg::*;

	cw_t x_q [STEPS];
	cw_t y_q [STEPS];
	cw_t z_q [STEPS];
	cw_t x_c [STEPS];
	cw_t y_c [STEPS];
	cw_t z_c [STEPS];
	cw_t x_nx[STEPS];
	cw_t y_nx[STEPS];
	cw_t z_nx[STEPS];

	// stage inputs
	always_comb begin
		x_c[0] = CORDIC_GAIN;
		y_c[0] = '0;
		z_c[0] = z0;
		for (int n = 1; n < STEPS; n++) begin
			x_c[n] = x_q[n-1];
			y_c[n] = y_q[n-1];
			z_c[n] = z_q[n-1];
		end
	end

	// micro-rotation toward z = 0
	always_comb begin
		cw_t xs;
		cw_t ys;
		cw_t at;
		for (int n = 0; n < STEPS; n++) begin
			xs = x_c[n] >>> n;
			ys = y_c[n] >>> n;
			at = $signed({2'b00, ATAN_Q30[n]});
			if (!z_c[n][33]) begin
				x_nx[n] = x_c[n] - ys;
				y_nx[n] = y_c[n] + xs;
				z_nx[n] = z_c[n] - at;
			end else begin
				x_nx[n] = x_c[n] + ys;
				y_nx[n] = y_c[n] - xs;
				z_nx[n] = z_c[n] + at;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < STEPS; n++) begin
				x_q[n] <= x_nx[n];
				y_q[n] <= y_nx[n];
				z_q[n] <= z_nx[n];
			end
		end
	end

	assign cos_o = x_q[STEPS-1];
	assign sin_o = y_q[STEPS-1];

endmodule

// ===== rtl/aaru_checker.sv =====
// port-level checks for the axis-angle rotation update block, with its bind
// depends on aaru_pkg and axis_angle_rotation_update

module aaru_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input aaru_pkg::q30_t new_r0c0,
	input aaru_pkg::q30_t new_r2c2
);
	import aaru_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_r0c0) && $stable(new_r2c2))
		else $error("stalled result item changed");

	// input is only held off while a result is blocked at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// a blocked result always holds off the input
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result blocked");

endmodule

bind axis_angle_rotation_update aaru_checker u_aaru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.new_r0c0  (new_r0c0),
	.new_r2c2  (new_r2c2)
);
